/* rtl/c816pd_pkg.sv */
// Package for the 65816 instruction predecoder: mnemonic and mode codes,
// mode length table and the 256-entry opcode decode function.
// No dependencies.
package c816pd_pkg;

  typedef enum logic [6:0] {
    N_ADC, N_AND, N_ASL, N_BCC, N_BCS, N_BEQ, N_BIT, N_BMI, N_BNE, N_BPL,
    N_BRA, N_BRK, N_BRL, N_BVC, N_BVS, N_CLC, N_CLD, N_CLI, N_CLV, N_CMP,
    N_COP, N_CPX, N_CPY, N_DEC, N_DEX, N_DEY, N_EOR, N_INC, N_INX, N_INY,
    N_JMP, N_JSL, N_JSR, N_LDA, N_LDX, N_LDY, N_LSR, N_MVN, N_MVP, N_NOP,
    N_ORA, N_PEA, N_PEI, N_PER, N_PHA, N_PHB, N_PHD, N_PHK, N_PHP, N_PHX,
    N_PHY, N_PLA, N_PLB, N_PLD, N_PLP, N_PLX, N_PLY, N_REP, N_ROL, N_ROR,
    N_RTI, N_RTL, N_RTS, N_SBC, N_SEC, N_SED, N_SEI, N_SEP, N_STA, N_STP,
    N_STX, N_STY, N_STZ, N_TAX, N_TAY, N_TCD, N_TCS, N_TDC, N_TRB, N_TSB,
    N_TSC, N_TSX, N_TXA, N_TXS, N_TXY, N_TYA, N_TYX, N_WAI, N_WDM, N_XBA,
    N_XCE
  } mnem_t;

  typedef enum logic [4:0] {
    A_DP, A_DPX, A_DIX, A_DPY, A_DIY, A_DLY, A_DI, A_DL, A_AB, A_ABX, A_ABY,
    A_AI, A_AL, A_ALX, A_AIL, A_AIX, A_IM, A_SR, A_SRY, A_IMP, A_BM,
    A_RL8, A_RL16
  } amode_t;

  typedef struct packed {
    mnem_t  mn;
    amode_t md;
  } op_entry_t;

  // Decoded item travelling from decode stage to output register
  typedef struct packed {
    logic [6:0]  mn;
    logic [4:0]  md;
    logic [2:0]  len;
    logic [23:0] val;
    logic        wide;
  } pd_result_t;

  function automatic logic [2:0] mode_len(input amode_t md);
    logic [2:0] l;
    unique case (md)
      A_AB, A_ABX, A_ABY, A_AI, A_AIL, A_AIX, A_BM, A_RL16: l = 3'd3;
      A_AL, A_ALX:                                          l = 3'd4;
      A_IMP:                                                l = 3'd1;
      default:                                              l = 3'd2;
    endcase
    return l;
  endfunction

  function automatic op_entry_t op_decode(input logic [7:0] opc);
    op_entry_t e;
    unique case (opc)
      8'h00: e = '{N_BRK,A_DP};  8'h01: e = '{N_ORA,A_DIX}; 8'h02: e = '{N_COP,A_DP};
      8'h03: e = '{N_ORA,A_SR};  8'h04: e = '{N_TSB,A_DP};  8'h05: e = '{N_ORA,A_DP};
      8'h06: e = '{N_ASL,A_DP};  8'h07: e = '{N_ORA,A_DL};  8'h08: e = '{N_PHP,A_IMP};
      8'h09: e = '{N_ORA,A_IM};  8'h0A: e = '{N_ASL,A_IMP}; 8'h0B: e = '{N_PHD,A_IMP};
      8'h0C: e = '{N_TSB,A_AB};  8'h0D: e = '{N_ORA,A_AB};  8'h0E: e = '{N_ASL,A_AB};
      8'h0F: e = '{N_ORA,A_AL};
      8'h10: e = '{N_BPL,A_RL8}; 8'h11: e = '{N_ORA,A_DIY}; 8'h12: e = '{N_ORA,A_DI};
      8'h13: e = '{N_ORA,A_SRY}; 8'h14: e = '{N_TRB,A_DP};  8'h15: e = '{N_ORA,A_DPX};
      8'h16: e = '{N_ASL,A_DPX}; 8'h17: e = '{N_ORA,A_DLY}; 8'h18: e = '{N_CLC,A_IMP};
      8'h19: e = '{N_ORA,A_ABY}; 8'h1A: e = '{N_INC,A_IMP}; 8'h1B: e = '{N_TCS,A_IMP};
      8'h1C: e = '{N_TRB,A_AB};  8'h1D: e = '{N_ORA,A_ABX}; 8'h1E: e = '{N_ASL,A_ABX};
      8'h1F: e = '{N_ORA,A_ALX};
      8'h20: e = '{N_JSR,A_AB};  8'h21: e = '{N_AND,A_DIX}; 8'h22: e = '{N_JSL,A_AL};
      8'h23: e = '{N_AND,A_SR};  8'h24: e = '{N_BIT,A_DP};  8'h25: e = '{N_AND,A_DP};
      8'h26: e = '{N_ROL,A_DP};  8'h27: e = '{N_AND,A_DL};  8'h28: e = '{N_PLP,A_IMP};
      8'h29: e = '{N_AND,A_IM};  8'h2A: e = '{N_ROL,A_IMP}; 8'h2B: e = '{N_PLD,A_IMP};
      8'h2C: e = '{N_BIT,A_AB};  8'h2D: e = '{N_AND,A_AB};  8'h2E: e = '{N_ROL,A_AB};
      8'h2F: e = '{N_AND,A_AL};
      8'h30: e = '{N_BMI,A_RL8}; 8'h31: e = '{N_AND,A_DIY}; 8'h32: e = '{N_AND,A_DI};
      8'h33: e = '{N_AND,A_SRY}; 8'h34: e = '{N_BIT,A_DPX}; 8'h35: e = '{N_AND,A_DPX};
      8'h36: e = '{N_ROL,A_DPX}; 8'h37: e = '{N_AND,A_DLY}; 8'h38: e = '{N_SEC,A_IMP};
      8'h39: e = '{N_AND,A_ABY}; 8'h3A: e = '{N_DEC,A_IMP}; 8'h3B: e = '{N_TSC,A_IMP};
      8'h3C: e = '{N_BIT,A_ABX}; 8'h3D: e = '{N_AND,A_ABX}; 8'h3E: e = '{N_ROL,A_ABX};
      8'h3F: e = '{N_AND,A_ALX};
      8'h40: e = '{N_RTI,A_IMP}; 8'h41: e = '{N_EOR,A_DIX}; 8'h42: e = '{N_WDM,A_IM};
      8'h43: e = '{N_EOR,A_SR};  8'h44: e = '{N_MVP,A_BM};  8'h45: e = '{N_EOR,A_DP};
      8'h46: e = '{N_LSR,A_DP};  8'h47: e = '{N_EOR,A_DL};  8'h48: e = '{N_PHA,A_IMP};
      8'h49: e = '{N_EOR,A_IM};  8'h4A: e = '{N_LSR,A_IMP}; 8'h4B: e = '{N_PHK,A_IMP};
      8'h4C: e = '{N_JMP,A_AB};  8'h4D: e = '{N_EOR,A_AB};  8'h4E: e = '{N_LSR,A_AB};
      8'h4F: e = '{N_EOR,A_AL};
      8'h50: e = '{N_BVC,A_RL8}; 8'h51: e = '{N_EOR,A_DIY}; 8'h52: e = '{N_EOR,A_DI};
      8'h53: e = '{N_EOR,A_SRY}; 8'h54: e = '{N_MVN,A_BM};  8'h55: e = '{N_EOR,A_DPX};
      8'h56: e = '{N_LSR,A_DPX}; 8'h57: e = '{N_EOR,A_DLY}; 8'h58: e = '{N_CLI,A_IMP};
      8'h59: e = '{N_EOR,A_ABY}; 8'h5A: e = '{N_PHY,A_IMP}; 8'h5B: e = '{N_TCD,A_IMP};
      8'h5C: e = '{N_JMP,A_AL};  8'h5D: e = '{N_EOR,A_ABX}; 8'h5E: e = '{N_LSR,A_ABX};
      8'h5F: e = '{N_EOR,A_ALX};
      8'h60: e = '{N_RTS,A_IMP}; 8'h61: e = '{N_ADC,A_DIX}; 8'h62: e = '{N_PER,A_AB};
      8'h63: e = '{N_ADC,A_SR};  8'h64: e = '{N_STZ,A_DP};  8'h65: e = '{N_ADC,A_DP};
      8'h66: e = '{N_ROR,A_DP};  8'h67: e = '{N_ADC,A_DL};  8'h68: e = '{N_PLA,A_IMP};
      8'h69: e = '{N_ADC,A_IM};  8'h6A: e = '{N_ROR,A_IMP}; 8'h6B: e = '{N_RTL,A_IMP};
      8'h6C: e = '{N_JMP,A_AI};  8'h6D: e = '{N_ADC,A_AB};  8'h6E: e = '{N_ROR,A_AB};
      8'h6F: e = '{N_ADC,A_AL};
      8'h70: e = '{N_BVS,A_RL8}; 8'h71: e = '{N_ADC,A_DIY}; 8'h72: e = '{N_ADC,A_DI};
      8'h73: e = '{N_ADC,A_SRY}; 8'h74: e = '{N_STZ,A_DPX}; 8'h75: e = '{N_ADC,A_DPX};
      8'h76: e = '{N_ROR,A_DPX}; 8'h77: e = '{N_ADC,A_DLY}; 8'h78: e = '{N_SEI,A_IMP};
      8'h79: e = '{N_ADC,A_ABY}; 8'h7A: e = '{N_PLY,A_IMP}; 8'h7B: e = '{N_TDC,A_IMP};
      8'h7C: e = '{N_JMP,A_AIX}; 8'h7D: e = '{N_ADC,A_ABX}; 8'h7E: e = '{N_ROR,A_ABX};
      8'h7F: e = '{N_ADC,A_ALX};
      8'h80: e = '{N_BRA,A_RL8}; 8'h81: e = '{N_STA,A_DIX}; 8'h82: e = '{N_BRL,A_RL16};
      8'h83: e = '{N_STA,A_SR};  8'h84: e = '{N_STY,A_DP};  8'h85: e = '{N_STA,A_DP};
      8'h86: e = '{N_STX,A_DP};  8'h87: e = '{N_STA,A_DL};  8'h88: e = '{N_DEY,A_IMP};
      8'h89: e = '{N_BIT,A_IM};  8'h8A: e = '{N_TXA,A_IMP}; 8'h8B: e = '{N_PHB,A_IMP};
      8'h8C: e = '{N_STY,A_AB};  8'h8D: e = '{N_STA,A_AB};  8'h8E: e = '{N_STX,A_AB};
      8'h8F: e = '{N_STA,A_AL};
      8'h90: e = '{N_BCC,A_RL8}; 8'h91: e = '{N_STA,A_DIY}; 8'h92: e = '{N_STA,A_DI};
      8'h93: e = '{N_STA,A_SRY}; 8'h94: e = '{N_STY,A_DPX}; 8'h95: e = '{N_STA,A_DPX};
      8'h96: e = '{N_STX,A_DPY}; 8'h97: e = '{N_STA,A_DLY}; 8'h98: e = '{N_TYA,A_IMP};
      8'h99: e = '{N_STA,A_ABY}; 8'h9A: e = '{N_TXS,A_IMP}; 8'h9B: e = '{N_TXY,A_IMP};
      8'h9C: e = '{N_STZ,A_AB};  8'h9D: e = '{N_STA,A_ABX}; 8'h9E: e = '{N_STZ,A_ABX};
      8'h9F: e = '{N_STA,A_ALX};
      8'hA0: e = '{N_LDY,A_IM};  8'hA1: e = '{N_LDA,A_DIX}; 8'hA2: e = '{N_LDX,A_IM};
      8'hA3: e = '{N_LDA,A_SR};  8'hA4: e = '{N_LDY,A_DP};  8'hA5: e = '{N_LDA,A_DP};
      8'hA6: e = '{N_LDX,A_DP};  8'hA7: e = '{N_LDA,A_DL};  8'hA8: e = '{N_TAY,A_IMP};
      8'hA9: e = '{N_LDA,A_IM};  8'hAA: e = '{N_TAX,A_IMP}; 8'hAB: e = '{N_PLB,A_IMP};
      8'hAC: e = '{N_LDY,A_AB};  8'hAD: e = '{N_LDA,A_AB};  8'hAE: e = '{N_LDX,A_AB};
      8'hAF: e = '{N_LDA,A_AL};
      8'hB0: e = '{N_BCS,A_RL8}; 8'hB1: e = '{N_LDA,A_DIY}; 8'hB2: e = '{N_LDA,A_DI};
      8'hB3: e = '{N_LDA,A_SRY}; 8'hB4: e = '{N_LDY,A_DPX}; 8'hB5: e = '{N_LDA,A_DPX};
      8'hB6: e = '{N_LDX,A_DPY}; 8'hB7: e = '{N_LDA,A_DLY}; 8'hB8: e = '{N_CLV,A_IMP};
      8'hB9: e = '{N_LDA,A_ABY}; 8'hBA: e = '{N_TSX,A_IMP}; 8'hBB: e = '{N_TYX,A_IMP};
      8'hBC: e = '{N_LDY,A_ABX}; 8'hBD: e = '{N_LDA,A_ABX}; 8'hBE: e = '{N_LDX,A_ABY};
      8'hBF: e = '{N_LDA,A_ALX};
      8'hC0: e = '{N_CPY,A_IM};  8'hC1: e = '{N_CMP,A_DIX}; 8'hC2: e = '{N_REP,A_IM};
      8'hC3: e = '{N_CMP,A_SR};  8'hC4: e = '{N_CPY,A_DP};  8'hC5: e = '{N_CMP,A_DP};
      8'hC6: e = '{N_DEC,A_DP};  8'hC7: e = '{N_CMP,A_DL};  8'hC8: e = '{N_INY,A_IMP};
      8'hC9: e = '{N_CMP,A_IM};  8'hCA: e = '{N_DEX,A_IMP}; 8'hCB: e = '{N_WAI,A_IMP};
      8'hCC: e = '{N_CPY,A_AB};  8'hCD: e = '{N_CMP,A_AB};  8'hCE: e = '{N_DEC,A_AB};
      8'hCF: e = '{N_CMP,A_AL};
      8'hD0: e = '{N_BNE,A_RL8}; 8'hD1: e = '{N_CMP,A_DIY}; 8'hD2: e = '{N_CMP,A_DI};
      8'hD3: e = '{N_CMP,A_SRY}; 8'hD4: e = '{N_PEI,A_DI};  8'hD5: e = '{N_CMP,A_DPX};
      8'hD6: e = '{N_DEC,A_DPX}; 8'hD7: e = '{N_CMP,A_DLY}; 8'hD8: e = '{N_CLD,A_IMP};
      8'hD9: e = '{N_CMP,A_ABY}; 8'hDA: e = '{N_PHX,A_IMP}; 8'hDB: e = '{N_STP,A_IMP};
      8'hDC: e = '{N_JMP,A_AIL}; 8'hDD: e = '{N_CMP,A_ABX}; 8'hDE: e = '{N_DEC,A_ABX};
      8'hDF: e = '{N_CMP,A_ALX};
      8'hE0: e = '{N_CPX,A_IM};  8'hE1: e = '{N_SBC,A_DIX}; 8'hE2: e = '{N_SEP,A_IM};
      8'hE3: e = '{N_SBC,A_SR};  8'hE4: e = '{N_CPX,A_DP};  8'hE5: e = '{N_SBC,A_DP};
      8'hE6: e = '{N_INC,A_DP};  8'hE7: e = '{N_SBC,A_DL};  8'hE8: e = '{N_INX,A_IMP};
      8'hE9: e = '{N_SBC,A_IM};  8'hEA: e = '{N_NOP,A_IMP}; 8'hEB: e = '{N_XBA,A_IMP};
      8'hEC: e = '{N_CPX,A_AB};  8'hED: e = '{N_SBC,A_AB};  8'hEE: e = '{N_INC,A_AB};
      8'hEF: e = '{N_SBC,A_AL};
      8'hF0: e = '{N_BEQ,A_RL8}; 8'hF1: e = '{N_SBC,A_DIY}; 8'hF2: e = '{N_SBC,A_DI};
      8'hF3: e = '{N_SBC,A_SRY}; 8'hF4: e = '{N_PEA,A_AB};  8'hF5: e = '{N_SBC,A_DPX};
      8'hF6: e = '{N_INC,A_DPX}; 8'hF7: e = '{N_SBC,A_DLY}; 8'hF8: e = '{N_SED,A_IMP};
      8'hF9: e = '{N_SBC,A_ABY}; 8'hFA: e = '{N_PLX,A_IMP}; 8'hFB: e = '{N_XCE,A_IMP};
      8'hFC: e = '{N_JSR,A_AIX}; 8'hFD: e = '{N_SBC,A_ABX}; 8'hFE: e = '{N_INC,A_ABX};
      default: e = '{N_SBC,A_ALX};
    endcase
    return e;
  endfunction

endpackage

/* rtl/c816pd_decode.sv */
// Decode logic: table lookup, length, immediate widening and branch targets.
// Depends on c816pd_pkg.
module c816pd_decode (
  input  logic [7:0]             opcode_byte,
  input  logic [7:0]             byte_one,
  input  logic [7:0]             byte_two,
  input  logic [7:0]             byte_three,
  input  logic [15:0]            pc,
  input  logic [7:0]             bank,
  input  logic                   e_flag,
  input  logic                   m_flag,
  input  logic                   x_flag,
  output c816pd_pkg::pd_result_t res
);

  c816pd_pkg::op_entry_t ent;
  logic [15:0] word;
  logic [15:0] off8;
  logic [15:0] br8;
  logic [15:0] br16;
  logic        xcls;
  logic        fixed_w;

  // Table lookup and branch adders
  always_comb begin
    ent  = c816pd_pkg::op_decode(opcode_byte);
    word = {byte_two, byte_one};
    off8 = {{8{byte_one[7]}}, byte_one};
    br8  = pc + 16'd2 + off8;
    br16 = pc + 16'd3 + word;
    xcls = (ent.mn == c816pd_pkg::N_LDX) || (ent.mn == c816pd_pkg::N_LDY) ||
           (ent.mn == c816pd_pkg::N_CPX) || (ent.mn == c816pd_pkg::N_CPY);
    fixed_w = (ent.mn == c816pd_pkg::N_WDM) || (ent.mn == c816pd_pkg::N_REP) ||
              (ent.mn == c816pd_pkg::N_SEP);
  end

  // Result assembly
  always_comb begin
    res.mn   = ent.mn;
    res.md   = ent.md;
    res.len  = c816pd_pkg::mode_len(ent.md);
    res.val  = 24'd0;
    res.wide = 1'b0;
    unique case (res.len)
      3'd2: begin
        res.val = {16'd0, byte_one};
        if (ent.md == c816pd_pkg::A_RL8) begin
          res.val = {bank, br8};
        end else if (ent.md == c816pd_pkg::A_IM && !e_flag && !fixed_w &&
                     ((xcls && !x_flag) || (!xcls && !m_flag))) begin
          res.val  = {8'd0, word};
          res.len  = 3'd3;
          res.wide = 1'b1;
        end
      end
      3'd3: begin
        if (ent.md == c816pd_pkg::A_RL16 || ent.mn == c816pd_pkg::N_PER) begin
          res.val = {bank, br16};
        end else begin
          res.val = {8'd0, word};
        end
      end
      3'd4: res.val = {byte_three, word};
      default: res.val = 24'd0;
    endcase
  end

endmodule

/* rtl/cpu65816_instruction_predecoder.sv */
// 65816 instruction predecoder: one decode stage into an output register
// with a skid register. Depends on c816pd_pkg and c816pd_decode.
//
// Takes one instruction window per cycle while in_tready is high and gives
// its mnemonic, addressing mode, length and operand from the output register.
// Throughput is one item per cycle while the sink keeps up, set by the single
// registered decode stage. A skid register takes one item while the output
// stalls, so no request is lost while the sink holds off.
module cpu65816_instruction_predecoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: opcode_byte, operand_byte_one, operand_byte_two,
  //        operand_byte_three, program_counter, program_bank
  input  logic [55:0] in_tdata,
  // tuser: emulation_flag, memory_width_flag, index_width_flag
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: mnemonic_index, address_mode, instruction_length,
  //        operand_value, wide_immediate, zero pad
  output logic [47:0] out_tdata
);

  c816pd_pkg::pd_result_t dec;
  c816pd_pkg::pd_result_t out_r, skid_r;
  logic out_vld_r, skid_vld_r;
  logic in_acc, out_acc;

  c816pd_decode u_dec (
    .opcode_byte (in_tdata[7:0]),
    .byte_one    (in_tdata[15:8]),
    .byte_two    (in_tdata[23:16]),
    .byte_three  (in_tdata[31:24]),
    .pc          (in_tdata[47:32]),
    .bank        (in_tdata[55:48]),
    .e_flag      (in_tuser[0]),
    .m_flag      (in_tuser[1]),
    .x_flag      (in_tuser[2]),
    .res         (dec)
  );

  assign in_tready  = !skid_vld_r;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_acc    = out_vld_r && out_tready;
  assign out_tdata  = {8'd0, out_r.wide, out_r.val, out_r.len, out_r.md, out_r.mn};

  // Output and skid control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (!out_vld_r || out_acc) begin
        out_vld_r  <= skid_vld_r || in_acc;
        skid_vld_r <= 1'b0;
      end else if (in_acc) begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!out_vld_r || out_acc) begin
      out_r <= skid_vld_r ? skid_r : dec;
    end
    if (in_acc && out_vld_r && !out_acc) begin
      skid_r <= dec;
    end
  end

  // Skid only fills while the output is stalled
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r) else $error("skid full with output empty");
  // An accepted item shows at the output next cycle when nothing stalls
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (!out_vld_r || out_acc)) |=> out_vld_r)
    else $error("accepted item missing");
  // A stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |=> $stable(out_tdata))
    else $error("stalled result changed");

endmodule
